// ===== hdl/two_priority_head_drop_queue_assert.svh =====
// ============================================================================
// Assertion macros for the two-priority head-drop queue.
// Each macro wraps one clocked concurrent assertion that is held off in reset.
// ============================================================================
`ifndef TWO_PRIORITY_HEAD_DROP_QUEUE_ASSERT_SVH
`define TWO_PRIORITY_HEAD_DROP_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define TPQ_ASSERT_DLY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== hdl/tpq_pkg.sv =====
// ============================================================================
// tpq_pkg
// Shared sizes, command codes and the command record that travels from the
// front end to the back end of the two-priority head-drop queue.
// ============================================================================
package tpq_pkg;

    // Entries in each ring and bits of one message handle.
    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_W    = 16;

    // Derived widths of the ring pointers and fill counts.
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    // Size register, total count and statistics counters.
    localparam int CFG_W     = 5;
    localparam int CFG_RESET = 16;
    localparam int LIM_W     = (CFG_W > FILL_W) ? CFG_W : FILL_W;
    localparam int TOTAL_W   = 6;
    localparam int CNT_W     = 32;

    // Command codes carried by the func field.
    typedef enum logic [1:0] {
        FUNC_ENQ    = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REPORT = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef logic [HANDLE_W-1:0] t_handle;

    // One decoded command waiting for the back end.
    typedef struct packed {
        logic    valid;
        t_func   func;
        t_handle handle;
        logic    high;
        logic    ok;
    } t_cmd;

endpackage

// ===== hdl/two_priority_head_drop_queue.sv =====
// ============================================================================
// two_priority_head_drop_queue
// Strict-priority pair of head-drop message queues with link status and
// transmission statistics.
// ============================================================================
// A command transfer happens on a rising edge with start high and busy low.
// Its result is registered and shows when o_done is high for exactly one
// cycle; the receiver cannot stall it, so it must take every result as it
// comes. The back end retires one command per cycle, so a new command may
// be given every cycle and busy stays low outside reset; the two-entry
// command queue between the decode stage and the execute stage only fills
// if that changes. Status fields (queued total, counters, link state) show
// the state right after the command of the same result.
module two_priority_head_drop_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  tpq_pkg::t_handle            i_message_handle,
    input  logic                        i_high_priority,
    input  logic                        i_send_ok,
    input  logic                        i_cfg_we,
    input  logic [tpq_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                        o_done,
    output logic                        o_accepted,
    output logic                        o_dropped_oldest,
    output logic                        o_msg_valid,
    output tpq_pkg::t_handle            o_msg_out,
    output logic                        o_msg_was_high,
    output logic [tpq_pkg::TOTAL_W-1:0] o_queued_total,
    output logic [tpq_pkg::CNT_W-1:0]   o_sent_count,
    output logic [tpq_pkg::CNT_W-1:0]   o_dropped_count,
    output logic                        o_link_broken
);
    import tpq_pkg::*;

    `include "two_priority_head_drop_queue_assert.svh"

    t_cmd w_cmd;

    // Decode stage and command queue.
    tpq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_message_handle (i_message_handle),
        .i_high_priority  (i_high_priority),
        .i_send_ok        (i_send_ok),
        .o_cmd            (w_cmd)
    );

    // Execute stage with both rings.
    tpq_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_accepted       (o_accepted),
        .o_dropped_oldest (o_dropped_oldest),
        .o_msg_valid      (o_msg_valid),
        .o_msg_out        (o_msg_out),
        .o_msg_was_high   (o_msg_was_high),
        .o_queued_total   (o_queued_total),
        .o_sent_count     (o_sent_count),
        .o_dropped_count  (o_dropped_count),
        .o_link_broken    (o_link_broken)
    );

    // Every accepted command later raises o_done with its result.
    `TPQ_ASSERT_DLY(ap_cmd_result, start && !busy, 2, o_done, "command result missing")

    // A drop only happens on an accepted enqueue, never alongside a pop.
    `TPQ_ASSERT_NOW(ap_drop_enq, o_done && o_dropped_oldest, o_accepted && !o_msg_valid,
        "drop without accepted enqueue")

    // The rings never hold more than their combined depth.
    `TPQ_ASSERT_NOW(ap_total_bound, 1'b1, o_queued_total <= TOTAL_W'(2 * QUEUE_DEPTH),
        "queued total above capacity")

    // Once broken, the link stays broken.
    `TPQ_ASSERT_NOW(ap_broken_sticky, 1'b1, !$fell(o_link_broken), "link recovered")

endmodule

// ===== hdl/tpq_front.sv =====
// ============================================================================
// tpq_front
// Takes command transfers, decodes the function code and holds them in a
// two-entry command queue that the back end drains one per cycle.
// ============================================================================
module tpq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      i_func,
    input  tpq_pkg::t_handle i_message_handle,
    input  logic            i_high_priority,
    input  logic            i_send_ok,
    output tpq_pkg::t_cmd   o_cmd
);
    import tpq_pkg::*;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = 1;
    localparam int CQ_CNT_W = 2;

    t_cmd                r_slot [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr_ptr;
    logic [CQ_PTR_W-1:0] r_rd_ptr;
    logic [CQ_CNT_W-1:0] r_count;
    logic                w_full;
    logic                w_push;
    logic                w_pop;
    t_cmd                w_new;

    // Queue status and handshake.
    assign w_full = (r_count == CQ_CNT_W'(CQ_DEPTH));
    assign busy   = w_full || !i_rst_n;
    assign w_push = start && !busy;
    assign w_pop  = (r_count != '0);

    // Decode the incoming transfer into a command record.
    always_comb begin
        w_new        = '0;
        w_new.valid  = 1'b1;
        w_new.func   = t_func'(i_func);
        w_new.handle = i_message_handle;
        w_new.high   = i_high_priority;
        w_new.ok     = i_send_ok;
    end

    // Head of the queue goes to the back end every cycle it is not empty.
    always_comb begin
        o_cmd       = r_slot[r_rd_ptr];
        o_cmd.valid = w_pop;
    end

    // Queue pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CQ_CNT_W'(w_push) - CQ_CNT_W'(w_pop);
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_new;
        end
    end

endmodule

// ===== hdl/tpq_ring.sv =====
// ============================================================================
// tpq_ring
// One bounded ring of message handles. A push onto a ring at its limit
// stores the new handle, drops the oldest one and advances the head, or is
// lost on an empty ring; a pop registers the head entry as the popped handle.
// ============================================================================
module tpq_ring (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_pop,
    input  tpq_pkg::t_handle            i_handle,
    input  logic [tpq_pkg::FILL_W-1:0]  i_limit,
    output logic                        o_at_limit,
    output logic [tpq_pkg::FILL_W-1:0]  o_fill,
    output tpq_pkg::t_handle            o_pop_data
);
    import tpq_pkg::*;

    localparam int SUM_W = FILL_W + 1;

    t_handle           r_store [QUEUE_DEPTH];
    t_handle           r_pop_data;
    logic [PTR_W-1:0]  r_head;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  w_tail_sum;
    logic [SUM_W-1:0]  w_head_sum;
    logic [PTR_W-1:0]  w_tail;
    logic [PTR_W-1:0]  w_head_inc;
    logic              w_write;

    // Tail slot is head plus fill, wrapped once.
    always_comb begin
        w_tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
        if (w_tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            w_tail_sum = w_tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        w_tail = w_tail_sum[PTR_W-1:0];
        w_head_sum = SUM_W'(r_head) + SUM_W'(1);
        if (w_head_sum >= SUM_W'(QUEUE_DEPTH)) begin
            w_head_sum = '0;
        end
        w_head_inc = w_head_sum[PTR_W-1:0];
    end

    assign o_at_limit = (r_fill >= i_limit);
    assign o_fill     = r_fill;
    assign o_pop_data = r_pop_data;
    assign w_write    = i_push && (!o_at_limit || (r_fill != '0));

    // Head and fill updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_push) begin
            if (!o_at_limit) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (r_fill != '0) begin
                r_head <= w_head_inc;
            end
        end else if (i_pop) begin
            r_head <= w_head_inc;
            r_fill <= r_fill - FILL_W'(1);
        end
    end

    // Handle storage; the head entry is read out at the edge that pops it.
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_store[w_tail] <= i_handle;
        end
        if (i_pop && !i_push) begin
            r_pop_data <= r_store[r_head];
        end
    end

endmodule

// ===== hdl/tpq_back.sv =====
// ============================================================================
// tpq_back
// Executes one command per cycle against the two rings, keeps the link and
// statistics state and registers the result for its one-cycle strobe.
// ============================================================================
module tpq_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tpq_pkg::t_cmd               i_cmd,
    input  logic                        i_cfg_we,
    input  logic [tpq_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                        o_done,
    output logic                        o_accepted,
    output logic                        o_dropped_oldest,
    output logic                        o_msg_valid,
    output tpq_pkg::t_handle            o_msg_out,
    output logic                        o_msg_was_high,
    output logic [tpq_pkg::TOTAL_W-1:0] o_queued_total,
    output logic [tpq_pkg::CNT_W-1:0]   o_sent_count,
    output logic [tpq_pkg::CNT_W-1:0]   o_dropped_count,
    output logic                        o_link_broken
);
    import tpq_pkg::*;

    logic [CFG_W-1:0]  r_size;
    logic [CNT_W-1:0]  r_sent;
    logic [CNT_W-1:0]  r_drops;
    logic              r_broken;
    logic              r_done;
    logic              r_accepted;
    logic              r_dropped;
    logic              r_msg_valid;
    logic              r_msg_high;

    logic [LIM_W-1:0]  w_size_ext;
    logic [FILL_W-1:0] w_limit;
    logic              w_live;
    logic              w_enq;
    logic              w_pop_any;
    logic              w_rep;
    logic              w_push_hi;
    logic              w_push_lo;
    logic              w_pop_hi;
    logic              w_pop_lo;
    logic              w_drop;
    logic              hi_at_limit;
    logic              lo_at_limit;
    logic [FILL_W-1:0] hi_fill;
    logic [FILL_W-1:0] lo_fill;
    t_handle           hi_pop_data;
    t_handle           lo_pop_data;

    // Size register clipped to the ring depth.
    always_comb begin
        w_size_ext = LIM_W'(r_size);
        if (w_size_ext > LIM_W'(QUEUE_DEPTH)) begin
            w_limit = FILL_W'(QUEUE_DEPTH);
        end else begin
            w_limit = FILL_W'(w_size_ext);
        end
    end

    // Command decode; nothing acts once the link is broken.
    assign w_live    = i_cmd.valid && !r_broken;
    assign w_enq     = w_live && (i_cmd.func == FUNC_ENQ);
    assign w_pop_any = w_live && (i_cmd.func == FUNC_POP);
    assign w_rep     = w_live && (i_cmd.func == FUNC_REPORT);
    assign w_push_hi = w_enq && i_cmd.high;
    assign w_push_lo = w_enq && !i_cmd.high;
    assign w_pop_hi  = w_pop_any && (hi_fill != '0);
    assign w_pop_lo  = w_pop_any && (hi_fill == '0) && (lo_fill != '0);
    assign w_drop    = w_enq && (i_cmd.high ? hi_at_limit : lo_at_limit);

    tpq_ring u_hi_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push_hi),
        .i_pop      (w_pop_hi),
        .i_handle   (i_cmd.handle),
        .i_limit    (w_limit),
        .o_at_limit (hi_at_limit),
        .o_fill     (hi_fill),
        .o_pop_data (hi_pop_data)
    );

    tpq_ring u_lo_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push_lo),
        .i_pop      (w_pop_lo),
        .i_handle   (i_cmd.handle),
        .i_limit    (w_limit),
        .o_at_limit (lo_at_limit),
        .o_fill     (lo_fill),
        .o_pop_data (lo_pop_data)
    );

    // Size register, link state and statistics counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= CFG_W'(CFG_RESET);
            r_sent   <= '0;
            r_drops  <= '0;
            r_broken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (w_drop) begin
                r_drops <= r_drops + CNT_W'(1);
            end
            if (w_rep && i_cmd.ok) begin
                r_sent <= r_sent + CNT_W'(1);
            end
            if (w_rep && !i_cmd.ok) begin
                r_broken <= 1'b1;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.valid;
        end
    end

    // Result flags; the popped handle itself is registered inside its ring.
    always_ff @(posedge i_clk) begin
        r_accepted  <= w_enq;
        r_dropped   <= w_drop;
        r_msg_valid <= w_pop_hi || w_pop_lo;
        r_msg_high  <= w_pop_hi;
    end

    // The handle shows only when a pop produced one.
    always_comb begin
        if (r_msg_high) begin
            o_msg_out = hi_pop_data;
        end else if (r_msg_valid) begin
            o_msg_out = lo_pop_data;
        end else begin
            o_msg_out = '0;
        end
    end

    assign o_done           = r_done;
    assign o_accepted       = r_accepted;
    assign o_dropped_oldest = r_dropped;
    assign o_msg_valid      = r_msg_valid;
    assign o_msg_was_high   = r_msg_high;
    assign o_queued_total   = TOTAL_W'(hi_fill) + TOTAL_W'(lo_fill);
    assign o_sent_count     = r_sent;
    assign o_dropped_count  = r_drops;
    assign o_link_broken    = r_broken;

endmodule

// ===== verif/tb_two_priority_head_drop_queue.sv =====
// ============================================================================
// tb_two_priority_head_drop_queue
// Self-checking bench for the strict-priority head-drop queue pair. Commands
// are sent through the start/busy handshake with random gaps, and a local
// copy of both rings, the counters and the link state predicts every result.
// A checker compares each strobed result with the oldest prediction.
// ============================================================================
module tb_two_priority_head_drop_queue;
    import tpq_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SEG_ITEMS    = 150;
    localparam int HIGH_Q       = 1;
    localparam int LOW_Q        = 0;
    localparam int MAX_REPORTS  = 10;

    // One predicted result, field for field as the block reports it.
    typedef struct packed {
        logic                accepted;
        logic                dropped;
        logic                valid;
        t_handle             msg;
        logic                was_high;
        logic [TOTAL_W-1:0]  total;
        logic [CNT_W-1:0]    sent;
        logic [CNT_W-1:0]    drops;
        logic                broken;
    } t_queue_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_func = FUNC_NOP;
    t_handle              i_message_handle = '0;
    logic                 i_high_priority = 1'b0;
    logic                 i_send_ok = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_done;
    logic                 o_accepted;
    logic                 o_dropped_oldest;
    logic                 o_msg_valid;
    t_handle              o_msg_out;
    logic                 o_msg_was_high;
    logic [TOTAL_W-1:0]   o_queued_total;
    logic [CNT_W-1:0]     o_sent_count;
    logic [CNT_W-1:0]     o_dropped_count;
    logic                 o_link_broken;

    // Local copy of the queue state.
    t_handle              ring [2][QUEUE_DEPTH];
    logic [PTR_W-1:0]     ring_head [2];
    logic [FILL_W-1:0]    ring_fill [2];
    logic [CFG_W-1:0]     size_reg = CFG_W'(CFG_RESET);
    logic [CNT_W-1:0]     sent_total = '0;
    logic [CNT_W-1:0]     drop_total = '0;
    logic                 link_down = 1'b0;

    t_queue_result        pending_results [$];
    int                   mismatch_count = 0;
    int                   result_index = 0;
    int                   cycle_count = 0;

    two_priority_head_drop_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_message_handle (i_message_handle),
        .i_high_priority  (i_high_priority),
        .i_send_ok        (i_send_ok),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_accepted       (o_accepted),
        .o_dropped_oldest (o_dropped_oldest),
        .o_msg_valid      (o_msg_valid),
        .o_msg_out        (o_msg_out),
        .o_msg_was_high   (o_msg_was_high),
        .o_queued_total   (o_queued_total),
        .o_sent_count     (o_sent_count),
        .o_dropped_count  (o_dropped_count),
        .o_link_broken    (o_link_broken)
    );

    // Free-running clock.
    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("two_priority_head_drop_queue test failed");
            $finish;
        end
    end

    // Apply one command to the local queue state and return what it reports.
    function automatic t_queue_result advance_queues(t_func f, t_handle h, logic hp,
                                                     logic ok);
        t_queue_result r;
        int lim;
        int q;
        int slot;
        r = '0;
        lim = (int'(size_reg) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(size_reg);
        q = hp ? HIGH_Q : LOW_Q;
        case (f)
            FUNC_ENQ: begin
                if (!link_down) begin
                    r.accepted = 1'b1;
                    slot = (int'(ring_head[q]) + int'(ring_fill[q])) % QUEUE_DEPTH;
                    if (int'(ring_fill[q]) < lim) begin
                        ring[q][slot] = h;
                        ring_fill[q] = ring_fill[q] + 1'b1;
                    end else begin
                        // Full (or over a lowered size): the oldest entry gives way.
                        if (ring_fill[q] != 0) begin
                            ring[q][slot] = h;
                            ring_head[q] = PTR_W'((int'(ring_head[q]) + 1) % QUEUE_DEPTH);
                        end
                        r.dropped = 1'b1;
                        drop_total = drop_total + 1'b1;
                    end
                end
            end
            FUNC_POP: begin
                if (!link_down) begin
                    q = (ring_fill[HIGH_Q] != 0) ? HIGH_Q : LOW_Q;
                    if (ring_fill[q] != 0) begin
                        r.valid = 1'b1;
                        r.msg = ring[q][ring_head[q]];
                        r.was_high = (q == HIGH_Q);
                        ring_head[q] = PTR_W'((int'(ring_head[q]) + 1) % QUEUE_DEPTH);
                        ring_fill[q] = ring_fill[q] - 1'b1;
                    end
                end
            end
            FUNC_REPORT: begin
                if (!link_down) begin
                    if (ok) sent_total = sent_total + 1'b1;
                    else link_down = 1'b1;
                end
            end
            default: ;
        endcase
        r.total = TOTAL_W'(int'(ring_fill[LOW_Q]) + int'(ring_fill[HIGH_Q]));
        r.sent = sent_total;
        r.drops = drop_total;
        r.broken = link_down;
        return r;
    endfunction

    // Count a failure; only the first few are printed.
    function automatic void note_failure(string text);
        if (mismatch_count < MAX_REPORTS) $display("MISMATCH result %0d: %s", result_index, text);
        mismatch_count++;
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endfunction

    // Result checker: every strobed result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (pending_results.size() == 0) begin
                note_failure("result arrived with nothing pending");
            end else begin
                want = pending_results.pop_front();
                check_field("accepted", want.accepted, o_accepted);
                check_field("dropped_oldest", want.dropped, o_dropped_oldest);
                check_field("msg_valid", want.valid, o_msg_valid);
                check_field("msg_out", want.msg, o_msg_out);
                check_field("msg_was_high", want.was_high, o_msg_was_high);
                check_field("queued_total", want.total, o_queued_total);
                check_field("sent_count", want.sent, o_sent_count);
                check_field("dropped_count", want.drops, o_dropped_count);
                check_field("link_broken", want.broken, o_link_broken);
            end
            result_index++;
        end
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Hold start low for a number of cycles, with junk on the data lines.
    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
            i_func = 2'($urandom_range(0, 3));
            i_message_handle = t_handle'($urandom);
            i_high_priority = 1'($urandom);
            i_send_ok = 1'($urandom);
            @(posedge i_clk);
        end
    endtask

    // Present one command and wait for its transfer.
    task automatic send_item(t_func f, t_handle h, logic hp, logic ok);
        @(negedge i_clk);
        start = 1'b1;
        i_func = f;
        i_message_handle = h;
        i_high_priority = hp;
        i_send_ok = ok;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_results.insert(pending_results.size(), advance_queues(f, h, hp, ok));
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the queue size register while the block is idle.
    task automatic write_queue_size(logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        size_reg = v;
    endtask

    // One random command; reports fail only when link breaks are allowed.
    task automatic send_random(int enq_pct, int high_pct, bit allow_fail);
        int r;
        t_func f;
        logic ok;
        r = $urandom_range(0, 99);
        if (r < enq_pct) f = FUNC_ENQ;
        else if (r < enq_pct + 10) f = FUNC_REPORT;
        else if (r < enq_pct + 13) f = FUNC_NOP;
        else f = FUNC_POP;
        ok = 1'($urandom);
        if (f == FUNC_REPORT && !allow_fail) ok = 1'b1;
        send_item(f, t_handle'($urandom_range(0, 65535)),
                  logic'($urandom_range(0, 99) < high_pct), ok);
    endtask

    // Empty pops, priority order, extreme handles and the idle code.
    task automatic test_directed_basics();
        send_item(FUNC_POP, 16'h0000, 1'b0, 1'b0);
        send_item(FUNC_REPORT, 16'h0000, 1'b0, 1'b1);
        send_item(FUNC_NOP, 16'hFFFF, 1'b1, 1'b0);
        send_item(FUNC_ENQ, 16'h0000, 1'b0, 1'b1);
        send_item(FUNC_ENQ, 16'hFFFF, 1'b0, 1'b0);
        send_item(FUNC_ENQ, 16'hFFFF, 1'b1, 1'b1);
        send_item(FUNC_ENQ, 16'h0000, 1'b1, 1'b0);
        repeat (5) send_item(FUNC_POP, 16'hFFFF, 1'b1, 1'b1);
    endtask

    // Size zero, size one, a size lowered under the fill and one above depth.
    task automatic test_queue_size_edges();
        write_queue_size(5'd0);
        send_item(FUNC_ENQ, 16'hAAAA, 1'b1, 1'b0);
        write_queue_size(5'd1);
        send_item(FUNC_ENQ, 16'h1234, 1'b0, 1'b0);
        send_item(FUNC_ENQ, 16'h5678, 1'b0, 1'b0);
        write_queue_size(5'd0);
        send_item(FUNC_ENQ, 16'h9ABC, 1'b0, 1'b0);
        send_item(FUNC_POP, 16'h0000, 1'b0, 1'b0);
        write_queue_size(5'd31);
        repeat (3) send_item(FUNC_ENQ, t_handle'($urandom), 1'b1, 1'b0);
        repeat (3) send_item(FUNC_POP, 16'h0000, 1'b0, 1'b0);
    endtask

    // Random traffic over several size settings with shifting enqueue mixes.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] sizes [8];
        int               enq_mix [8];
        int               high_mix [8];
        sizes = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd3, 5'd10, 5'd5, 5'd16};
        enq_mix = '{50, 80, 50, 45, 60, 75, 55, 30};
        high_mix = '{50, 70, 50, 30, 50, 20, 80, 50};
        sizes[6] = 5'($urandom_range(0, 31));
        for (int s = 0; s < 8; s++) begin
            write_queue_size(sizes[s]);
            for (int i = 0; i < SEG_ITEMS; i++) begin
                // Sender holds off once per setting until the block is empty.
                if (i == SEG_ITEMS / 2) wait_drained();
                send_random(enq_mix[s], high_mix[s], 1'b0);
                // Every third stretch of 25 items runs without gaps.
                if ((i / 25) % 3 != 0) idle_cycles(pick_gap());
            end
        end
    endtask

    // Break the link, then show that all commands are refused or ignored.
    task automatic test_broken_link();
        repeat (8) send_random(70, 50, 1'b0);
        send_item(FUNC_REPORT, 16'h0000, 1'b0, 1'b0);
        send_item(FUNC_REPORT, 16'h0000, 1'b0, 1'b1);
        send_item(FUNC_REPORT, 16'h0000, 1'b0, 1'b0);
        send_item(FUNC_ENQ, 16'hFFFF, 1'b1, 1'b0);
        send_item(FUNC_POP, 16'h0000, 1'b0, 1'b0);
        write_queue_size(5'd16);
        for (int i = 0; i < 40; i++) begin
            send_random(40, 50, 1'b1);
            idle_cycles(pick_gap());
        end
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        for (int q = 0; q < 2; q++) begin
            ring_head[q] = '0;
            ring_fill[q] = '0;
            for (int k = 0; k < QUEUE_DEPTH; k++) ring[q][k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_basics();
        test_queue_size_edges();
        test_random_traffic();
        test_broken_link();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("two_priority_head_drop_queue test passed");
        end else begin
            $display("two_priority_head_drop_queue test failed");
        end
        $finish;
    end

endmodule

// ===== two_priority_head_drop_queue.f =====
+incdir+hdl
hdl/tpq_pkg.sv
hdl/tpq_front.sv
hdl/tpq_ring.sv
hdl/tpq_back.sv
hdl/two_priority_head_drop_queue.sv
verif/tb_two_priority_head_drop_queue.sv
